// File: hw/rtl/bmf_pkg.sv
`default_nettype none
package bmf_pkg;

   localparam int MAX_WIDTH_DEF  = 1024;
   localparam int MAX_RADIUS_DEF = 7;
   localparam int HEIGHT_LIMIT   = 4096;

   localparam int PIX_W        = 8;
   localparam int WIDTH_REG_W  = 11;
   localparam int HEIGHT_REG_W = 13;
   localparam int RADIUS_REG_W = 3;
   localparam int CSR_DATA_W   = 13;
   localparam int CSR_INDEX_W  = 2;
   localparam int HEIGHT_W     = 13;
   localparam int ROW_W        = 14;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_IMAGE_WIDTH   = 2'd0,
      CSR_IMAGE_HEIGHT  = 2'd1,
      CSR_KERNEL_RADIUS = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SUM,
      ST_FLUSH,
      ST_LOAD,
      ST_DIV,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic accept;
      logic win_step;
      logic div_load;
      logic div_step;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic due;
      logic win_last;
      logic div_last;
      logic out_free;
   } status_type;

endpackage
`default_nettype wire

// File: hw/rtl/bmf_req_if.sv
`default_nettype none
interface bmf_req_if;
   logic                       valid;
   logic                       ready;
   logic                       req_type;
   logic [bmf_pkg::PIX_W-1:0]  blue_in;
   logic [bmf_pkg::PIX_W-1:0]  green_in;
   logic [bmf_pkg::PIX_W-1:0]  red_in;

   modport source (output valid, req_type, blue_in, green_in, red_in, input ready);
   modport sink   (input valid, req_type, blue_in, green_in, red_in, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/bmf_rsp_if.sv
`default_nettype none
interface bmf_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [bmf_pkg::PIX_W-1:0]  blue_out;
   logic [bmf_pkg::PIX_W-1:0]  green_out;
   logic [bmf_pkg::PIX_W-1:0]  red_out;
   logic                       last;

   modport source (output valid, blue_out, green_out, red_out, last, input ready);
   modport sink   (input valid, blue_out, green_out, red_out, last, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/bmf_controller.sv
`default_nettype none
module bmf_controller (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output      logic                req_ready,
   input  wire bmf_pkg::status_type status,
   output      bmf_pkg::cmd_type    cmd
);

   bmf_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bmf_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      case (state_ff)
         bmf_pkg::ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
            if (req_valid && status.due) begin
               state_in = bmf_pkg::ST_SUM;
            end
         end
         bmf_pkg::ST_SUM: begin
            cmd.win_step = 1'b1;
            if (status.win_last) begin
               state_in = bmf_pkg::ST_FLUSH;
            end
         end
         bmf_pkg::ST_FLUSH: begin
            state_in = bmf_pkg::ST_LOAD;
         end
         bmf_pkg::ST_LOAD: begin
            cmd.div_load = 1'b1;
            state_in     = bmf_pkg::ST_DIV;
         end
         bmf_pkg::ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = bmf_pkg::ST_OUT;
            end
         end
         bmf_pkg::ST_OUT: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = bmf_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = bmf_pkg::ST_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire

// File: hw/rtl/bmf_datapath.sv
`default_nettype none
module bmf_datapath #(
   parameter int MAX_WIDTH  = bmf_pkg::MAX_WIDTH_DEF,
   parameter int MAX_RADIUS = bmf_pkg::MAX_RADIUS_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_we,
   input  wire logic [bmf_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire logic [bmf_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  wire logic                                req_type,
   input  wire logic [bmf_pkg::PIX_W-1:0]           blue_in,
   input  wire logic [bmf_pkg::PIX_W-1:0]           green_in,
   input  wire logic [bmf_pkg::PIX_W-1:0]           red_in,
   input  wire bmf_pkg::cmd_type                    cmd,
   output      bmf_pkg::status_type                 status,
   input  wire logic                                rsp_ready,
   output      logic                                rsp_valid,
   output      logic [bmf_pkg::PIX_W-1:0]           blue_out,
   output      logic [bmf_pkg::PIX_W-1:0]           green_out,
   output      logic [bmf_pkg::PIX_W-1:0]           red_out,
   output      logic                                last
);

   localparam int PW       = bmf_pkg::PIX_W;
   localparam int HW       = bmf_pkg::HEIGHT_W;
   localparam int COL_W    = $clog2(MAX_WIDTH);
   localparam int WID_W    = $clog2(MAX_WIDTH + 1);
   localparam int RAD_W    = $clog2(MAX_RADIUS + 1);
   localparam int WIN_W    = $clog2(2 * MAX_RADIUS + 1);
   localparam int RING_W   = $clog2(2 * MAX_RADIUS + 2);
   localparam int ADDR_W   = RING_W + COL_W;
   localparam int AREA_MAX = (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1);
   localparam int AREA_W   = $clog2(AREA_MAX + 1);
   localparam int SUM_W    = $clog2(AREA_MAX * 255 + 1);
   localparam int STEP_W   = $clog2(SUM_W);
   localparam int TOT_W    = WID_W + HW;
   localparam int POS_W    = TOT_W + 1;
   localparam int RR_W     = HW + 2;
   localparam int CC_W     = WID_W + 2;

   // configuration
   logic [bmf_pkg::WIDTH_REG_W-1:0]  width_ff;
   logic [bmf_pkg::HEIGHT_REG_W-1:0] height_ff;
   logic [bmf_pkg::RADIUS_REG_W-1:0] radius_ff;
   logic [WID_W-1:0]  w_eff;
   logic [HW-1:0]     h_eff;
   logic [RAD_W-1:0]  r_eff;
   logic [TOT_W-1:0]  total;
   logic [POS_W-1:0]  lag;
   logic [AREA_W-1:0] area;
   logic [RAD_W:0]    side;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= bmf_pkg::WIDTH_REG_W'(1024);
         height_ff <= bmf_pkg::HEIGHT_REG_W'(1024);
         radius_ff <= bmf_pkg::RADIUS_REG_W'(1);
      end else if (csr_we) begin
         case (csr_index)
            bmf_pkg::CSR_IMAGE_WIDTH:   width_ff  <= csr_wdata[bmf_pkg::WIDTH_REG_W-1:0];
            bmf_pkg::CSR_IMAGE_HEIGHT:  height_ff <= csr_wdata[bmf_pkg::HEIGHT_REG_W-1:0];
            bmf_pkg::CSR_KERNEL_RADIUS: radius_ff <= csr_wdata[bmf_pkg::RADIUS_REG_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (width_ff == '0) begin
         w_eff = WID_W'(1);
      end else if (32'(width_ff) > 32'(MAX_WIDTH)) begin
         w_eff = WID_W'(MAX_WIDTH);
      end else begin
         w_eff = WID_W'(width_ff);
      end
      if (height_ff == '0) begin
         h_eff = HW'(1);
      end else if (32'(height_ff) > 32'(bmf_pkg::HEIGHT_LIMIT)) begin
         h_eff = HW'(bmf_pkg::HEIGHT_LIMIT);
      end else begin
         h_eff = HW'(height_ff);
      end
      if (radius_ff == '0) begin
         r_eff = RAD_W'(1);
      end else if (32'(radius_ff) > 32'(MAX_RADIUS)) begin
         r_eff = RAD_W'(MAX_RADIUS);
      end else begin
         r_eff = RAD_W'(radius_ff);
      end
   end

   assign total = TOT_W'(w_eff) * TOT_W'(h_eff);
   assign lag   = POS_W'(r_eff) * POS_W'(w_eff) + POS_W'(r_eff);
   assign side  = {r_eff, 1'b1};
   assign area  = AREA_W'(side) * AREA_W'(side);

   // stream and output positions
   logic [bmf_pkg::ROW_W-1:0] row_ff;
   logic [COL_W-1:0]          col_ff;
   logic [POS_W-1:0]          pos_ff;
   logic [HW-1:0]             orow_ff;
   logic [COL_W-1:0]          ocol_ff;
   logic                      col_wrap;
   logic                      ocol_wrap;
   logic                      is_last;

   assign col_wrap  = (WID_W'(col_ff) + WID_W'(1)) == w_eff;
   assign ocol_wrap = (WID_W'(ocol_ff) + WID_W'(1)) == w_eff;
   assign is_last   = ocol_wrap && (orow_ff == h_eff - HW'(1));

   always_ff @(posedge clock) begin
      if (reset || csr_we || (cmd.out_load && is_last)) begin
         row_ff  <= '0;
         col_ff  <= '0;
         pos_ff  <= '0;
         orow_ff <= '0;
         ocol_ff <= '0;
      end else if (cmd.accept) begin
         pos_ff <= pos_ff + POS_W'(1);
         if (col_wrap) begin
            col_ff <= '0;
            row_ff <= row_ff + bmf_pkg::ROW_W'(1);
         end else begin
            col_ff <= col_ff + COL_W'(1);
         end
      end else if (cmd.out_load) begin
         if (ocol_wrap) begin
            ocol_ff <= '0;
            orow_ff <= orow_ff + HW'(1);
         end else begin
            ocol_ff <= ocol_ff + COL_W'(1);
         end
      end
   end

   // line store
   logic [3*PW-1:0]  mem [2**ADDR_W];
   logic [3*PW-1:0]  wr_data;
   logic [ADDR_W-1:0] wr_addr;
   logic [ADDR_W-1:0] rd_addr;
   logic [3*PW-1:0]  rd_data_ff;
   logic             in_image;

   assign in_image = pos_ff < POS_W'(total);
   assign wr_data  = (in_image && !req_type) ? {red_in, green_in, blue_in} : '0;
   assign wr_addr  = {row_ff[RING_W-1:0], col_ff};

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         mem[wr_addr] <= wr_data;
      end
      if (cmd.win_step) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // window walk
   logic [WIN_W-1:0] wi_ff, wj_ff;
   logic [WIN_W-1:0] win_end;
   logic [RR_W-1:0]  rr;
   logic [CC_W-1:0]  cc;
   logic             tap_ok;
   logic             rd_valid_ff;
   logic             rd_ok_ff;

   assign win_end = WIN_W'({r_eff, 1'b0});
   assign rr      = RR_W'(orow_ff) - RR_W'(r_eff) + RR_W'(wi_ff);
   assign cc      = CC_W'(ocol_ff) - CC_W'(r_eff) + CC_W'(wj_ff);
   assign tap_ok  = !rr[RR_W-1] && (rr < RR_W'(h_eff)) && !cc[CC_W-1] && (cc < CC_W'(w_eff));
   assign rd_addr = {rr[RING_W-1:0], cc[COL_W-1:0]};

   always_ff @(posedge clock) begin
      if (reset) begin
         wi_ff       <= '0;
         wj_ff       <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= cmd.win_step;
         if (cmd.accept) begin
            wi_ff <= '0;
            wj_ff <= '0;
         end else if (cmd.win_step) begin
            if (wj_ff == win_end) begin
               wj_ff <= '0;
               wi_ff <= wi_ff + WIN_W'(1);
            end else begin
               wj_ff <= wj_ff + WIN_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.win_step) begin
         rd_ok_ff <= tap_ok;
      end
   end

   // accumulate, then restoring divide by the window area; index 0 blue, 1 green, 2 red
   logic [SUM_W-1:0]  acc_ff [3];
   logic [SUM_W-1:0]  num_ff [3];
   logic [AREA_W-1:0] rem_ff [3];
   logic [AREA_W:0]   trial  [3];
   logic [STEP_W-1:0] step_ff;
   logic [PW-1:0]     out_ff [3];
   logic              last_ff;
   logic              rsp_valid_ff;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         trial[k] = {rem_ff[k], num_ff[k][SUM_W-1]};
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < 3; k++) begin
         if (cmd.accept) begin
            acc_ff[k] <= '0;
         end else if (rd_valid_ff && rd_ok_ff) begin
            acc_ff[k] <= acc_ff[k] + SUM_W'(rd_data_ff[PW*k +: PW]);
         end
         if (cmd.div_load) begin
            num_ff[k] <= acc_ff[k];
            rem_ff[k] <= '0;
         end else if (cmd.div_step) begin
            if (trial[k] >= (AREA_W + 1)'(area)) begin
               rem_ff[k] <= AREA_W'(trial[k] - (AREA_W + 1)'(area));
               num_ff[k] <= {num_ff[k][SUM_W-2:0], 1'b1};
            end else begin
               rem_ff[k] <= AREA_W'(trial[k]);
               num_ff[k] <= {num_ff[k][SUM_W-2:0], 1'b0};
            end
         end
         if (cmd.out_load) begin
            out_ff[k] <= num_ff[k][PW-1:0];
         end
      end
      if (cmd.out_load) begin
         last_ff <= is_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.div_load) begin
            step_ff <= '0;
         end else if (cmd.div_step) begin
            step_ff <= step_ff + STEP_W'(1);
         end
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign status.due      = pos_ff >= lag;
   assign status.win_last = (wi_ff == win_end) && (wj_ff == win_end);
   assign status.div_last = step_ff == STEP_W'(SUM_W - 1);
   assign status.out_free = !rsp_valid_ff || rsp_ready;

   assign rsp_valid = rsp_valid_ff;
   assign blue_out  = out_ff[0];
   assign green_out = out_ff[1];
   assign red_out   = out_ff[2];
   assign last      = last_ff;

endmodule
`default_nettype wire

// File: hw/rtl/box_mean_filter.sv
`default_nettype none
// RGB box mean filter with zero padding. Pixels stream in raster order, one per
// req beat; req_type 1 beats store a zero pixel and beats past the image push the
// last rows out. The result for a pixel leaves R*W+R beats after it entered, and
// the final result of an image carries last. A beat that completes a window blocks
// req while the window is read one tap per cycle from the single-port line store,
// one restoring divider per channel takes S steps, 16 at the default MAX_RADIUS,
// to divide by the window area, and the result waits for a free output register.
// Any csr write restarts the image at the first pixel; write csrs only while idle.
module box_mean_filter #(
   parameter int MAX_WIDTH  = bmf_pkg::MAX_WIDTH_DEF,
   parameter int MAX_RADIUS = bmf_pkg::MAX_RADIUS_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   bmf_req_if.sink                              req_chan,
   bmf_rsp_if.source                            rsp_chan,
   input  wire logic                            csr_we,
   input  wire logic [bmf_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [bmf_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   bmf_pkg::cmd_type    cmd;
   bmf_pkg::status_type status;

   bmf_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   bmf_datapath #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_RADIUS (MAX_RADIUS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_type  (req_chan.req_type),
      .blue_in   (req_chan.blue_in),
      .green_in  (req_chan.green_in),
      .red_in    (req_chan.red_in),
      .cmd       (cmd),
      .status    (status),
      .rsp_ready (rsp_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .blue_out  (rsp_chan.blue_out),
      .green_out (rsp_chan.green_out),
      .red_out   (rsp_chan.red_out),
      .last      (rsp_chan.last)
   );

endmodule
`default_nettype wire

// File: dv/box_mean_filter_test.sv
module box_mean_filter_test;
   import bmf_pkg::*;

   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE = 2'd3;
   localparam int RING_ROWS   = 2 * MAX_RADIUS_DEF + 2;
   localparam int STALL_LIMIT = 20000;
   localparam int SETTLE_CYC  = 300;
   localparam int RAND_ITEMS  = 1000;

   class box_mean_scoreboard;
      typedef struct packed {
         logic [7:0] blue;
         logic [7:0] green;
         logic [7:0] red;
         logic       last;
      } pix_mean_type;

      int unsigned  img_w, img_h, radius;
      logic [23:0]  rows [RING_ROWS][MAX_WIDTH_DEF];
      int           col_pos, row_pos;
      pix_mean_type pending_means[$];
      int           mismatches;

      function new();
         img_w = 1024;
         img_h = 1024;
         radius = 1;
         mismatches = 0;
         restart();
      endfunction

      function void restart();
         foreach (rows[i, j]) rows[i][j] = '0;
         col_pos = 0;
         row_pos = 0;
      endfunction

      function int clampv(int unsigned v, int lo, int hi);
         if (v < lo) return lo;
         if (v > hi) return hi;
         return v;
      endfunction

      function int eff_w();
         return clampv(img_w, 1, MAX_WIDTH_DEF);
      endfunction

      function int eff_h();
         return clampv(img_h, 1, HEIGHT_LIMIT);
      endfunction

      function int eff_r();
         return clampv(radius, 1, MAX_RADIUS_DEF);
      endfunction

      function void set_reg(logic [CSR_INDEX_W-1:0] idx, int unsigned val);
         case (idx)
            CSR_IMAGE_WIDTH:   img_w = val & 'h7ff;
            CSR_IMAGE_HEIGHT:  img_h = val & 'h1fff;
            CSR_KERNEL_RADIUS: radius = val & 'h7;
            default: ;
         endcase
         restart();
      endfunction

      function void note_beat(logic kind, logic [7:0] b, logic [7:0] g, logic [7:0] r);
         int w, h, rad, rowv, colv, total, pos, q, qr, qc, area;
         int unsigned sb, sg, sr;
         logic [23:0] v;
         pix_mean_type m;
         w = eff_w();
         h = eff_h();
         rad = eff_r();
         rowv = row_pos;
         colv = col_pos;
         total = w * h;
         pos = rowv * w + colv;
         if (colv >= w) colv = 0;
         v = '0;
         if (pos < total && kind == 1'b0) v = {r, g, b};
         rows[rowv % RING_ROWS][colv] = v;
         q = pos - (rad * w + rad);
         if (q >= 0 && q < total) begin
            qr = q / w;
            qc = q % w;
            sb = 0; sg = 0; sr = 0;
            area = (2 * rad + 1) * (2 * rad + 1);
            for (int y = qr - rad; y <= qr + rad; y++) begin
               if (y < 0 || y >= h) continue;
               for (int x = qc - rad; x <= qc + rad; x++) begin
                  if (x < 0 || x >= w) continue;
                  v = rows[y % RING_ROWS][x];
                  sb += v[7:0];
                  sg += v[15:8];
                  sr += v[23:16];
               end
            end
            m.blue = sb / area;
            m.green = sg / area;
            m.red = sr / area;
            m.last = (q == total - 1);
            pending_means.push_back(m);
            if (q == total - 1) begin
               col_pos = 0;
               row_pos = 0;
               return;
            end
         end
         colv++;
         if (colv >= w) begin
            colv = 0;
            rowv++;
         end
         col_pos = colv;
         row_pos = rowv;
      endfunction

      function void check_beat(logic [7:0] b, logic [7:0] g, logic [7:0] r, logic last);
         pix_mean_type got, want;
         got = {b, g, r, last};
         if (pending_means.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: unexpected rsp beat b=%0d g=%0d r=%0d last=%0b",
                        b, g, r, last);
            return;
         end
         want = pending_means.pop_front();
         if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: rsp exp b=%0d g=%0d r=%0d l=%0b got b=%0d g=%0d r=%0d l=%0b",
                        want.blue, want.green, want.red, want.last, b, g, r, last);
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                   csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   bmf_req_if req_chan ();
   bmf_rsp_if rsp_chan ();

   box_mean_filter u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   box_mean_scoreboard sb = new();
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int hold_left = 0;
   int idle_cycles = 0;
   int items_sent = 0;

   always #5 clock = ~clock;

   initial begin
      req_chan.valid = 1'b0;
      req_chan.req_type = 1'b0;
      req_chan.blue_in = '0;
      req_chan.green_in = '0;
      req_chan.red_in = '0;
      rsp_chan.ready = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready)
         sb.check_beat(rsp_chan.blue_out, rsp_chan.green_out, rsp_chan.red_out, rsp_chan.last);
      if (hold_left > 0) begin
         rsp_chan.ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else begin
         rsp_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   task automatic send_beat(logic kind, logic [7:0] b, logic [7:0] g, logic [7:0] r);
      req_chan.valid <= 1'b1;
      req_chan.req_type <= kind;
      req_chan.blue_in <= b;
      req_chan.green_in <= g;
      req_chan.red_in <= r;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      sb.note_beat(kind, b, g, r);
      items_sent++;
      if ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 2)) @(posedge clock);
      end
   endtask

   task automatic send_rand(logic kind);
      send_beat(kind, 8'($urandom_range(255)), 8'($urandom_range(255)),
                8'($urandom_range(255)));
   endtask

   task automatic write_csr(logic [CSR_INDEX_W-1:0] idx, int unsigned val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CSR_DATA_W'(val);
      @(posedge clock);
      sb.set_reg(idx, val);
   endtask

   task automatic configure(int unsigned w, int unsigned h, int unsigned r);
      write_csr(CSR_IMAGE_WIDTH, w);
      write_csr(CSR_IMAGE_HEIGHT, h);
      write_csr(CSR_KERNEL_RADIUS, r);
      if ($urandom_range(3) == 0) write_csr(CSR_SPARE, $urandom_range(8191));
      csr_we <= 1'b0;
   endtask

   task automatic settle();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (sb.pending_means.size() != 0) @(posedge clock);
      repeat (SETTLE_CYC) @(posedge clock);
   endtask

   task automatic set_mode(int m);
      case (m)
         0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
         1: begin send_idle_pct = 50; recv_stall_pct = 0;  end
         2: begin send_idle_pct = 0;  recv_stall_pct = 50; end
         default: begin send_idle_pct = 18; recv_stall_pct = 18; end
      endcase
   endtask

   // pixels with occasional in-image drain ticks, then the flush beats unless cut short
   task automatic run_image(int cut);
      int total, flush;
      total = sb.eff_w() * sb.eff_h();
      flush = sb.eff_r() * sb.eff_w() + sb.eff_r();
      for (int i = 0; i < total && i < cut; i++)
         send_rand($urandom_range(19) == 0);
      if (cut < total) return;
      for (int i = 0; i < flush; i++)
         send_rand(1'($urandom_range(1)));
   endtask

   initial begin
      int phase;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: 4x3 image, radius 1
      configure(4, 3, 1);
      send_beat(1'b0, 8'd0, 8'd0, 8'd0);
      send_beat(1'b0, 8'd255, 8'd255, 8'd255);
      send_beat(1'b0, 8'h55, 8'haa, 8'hff);
      send_beat(1'b0, 8'haa, 8'h55, 8'h00);
      for (int i = 0; i < 4; i++) send_beat(1'b0, 8'd255, 8'd255, 8'd255);
      send_beat(1'b1, 8'd255, 8'd255, 8'd255);
      send_beat(1'b0, 8'd1, 8'd128, 8'd254);
      send_beat(1'b0, 8'd255, 8'd0, 8'd255);
      send_beat(1'b0, 8'd0, 8'd255, 8'd0);
      send_beat(1'b1, 8'd0, 8'd0, 8'd0);
      send_beat(1'b0, 8'd255, 8'd255, 8'd255);
      send_beat(1'b1, 8'd0, 8'd0, 8'd0);
      send_beat(1'b0, 8'd255, 8'd255, 8'd255);
      send_beat(1'b1, 8'd0, 8'd0, 8'd0);
      settle();

      // register extremes: zero fields, saturating fields, largest radius
      configure(0, 0, 0);
      run_image(1 << 30);
      run_image(1 << 30);
      settle();
      configure(2047, 0, 1);
      run_image(40);
      settle();
      configure(1, 8191, 7);
      run_image(40);
      settle();
      configure(8, 5, 7);
      run_image(1 << 30);
      settle();

      // long receiver hold while the sender keeps pushing
      set_mode(0);
      configure(6, 4, 1);
      hold_left = 400;
      run_image(1 << 30);
      settle();

      items_sent = 0;
      phase = 0;
      while (items_sent < RAND_ITEMS) begin
         set_mode(phase % 4);
         configure($urandom_range(1, 12), $urandom_range(1, 6), $urandom_range(1, 7));
         repeat ($urandom_range(1, 2)) run_image(($urandom_range(9) == 0) ?
                                                $urandom_range(1, 20) : (1 << 30));
         settle();
         phase++;
      end

      if (sb.mismatches == 0 && sb.pending_means.size() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

// File: filelist.f
hw/rtl/bmf_pkg.sv
hw/rtl/bmf_req_if.sv
hw/rtl/bmf_rsp_if.sv
hw/rtl/bmf_controller.sv
hw/rtl/bmf_datapath.sv
hw/rtl/box_mean_filter.sv
dv/box_mean_filter_test.sv
